// File: design/ssf_pkg.sv
// ============================================================================
// ssf_pkg
// Shared types and constants for the steering safety filter.
// ============================================================================
package ssf_pkg;

    localparam int OMEGA_W    = 16;
    localparam int SPEED_W    = 15;
    localparam int GAIN_W     = 8;
    localparam int SLOW_W     = 9;
    localparam int AGE_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_X_W    = 24;
    localparam int MUL_Y_W    = 17;
    localparam int PROD_W     = MUL_X_W + MUL_Y_W;
    localparam int DEN_W      = SPEED_W + 8;
    localparam int NUM_W      = DEN_W + SPEED_W;
    localparam int DIV_STEPS  = SPEED_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [GAIN_W-1:0]  GAIN_MAX = 8'd253;
    localparam logic [SLOW_W-1:0]  SLOW_MAX = 9'd256;
    localparam logic [AGE_W-1:0]   AGE_MAX  = 16'hFFFF;

    localparam logic [GAIN_W-1:0]  GAIN_RST      = 8'd166;
    localparam logic [SPEED_W-1:0] LIMIT_RST     = 15'd3277;
    localparam logic [SPEED_W-1:0] CRUISE_RST    = 15'd410;
    localparam logic [SLOW_W-1:0]  SLOW_RST      = 9'd77;
    localparam logic [AGE_W-1:0]   STALE_LIM_RST = 16'd10;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_GO     = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN      = 3'd0,
        CFG_LIMIT     = 3'd1,
        CFG_CRUISE    = 3'd2,
        CFG_SLOW      = 3'd3,
        CFG_STALE_LIM = 3'd4,
        CFG_NEED_GO   = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_MUL3,
        S_DIFF,
        S_MUL4,
        S_DIVINIT,
        S_DIV,
        S_OUT
    } state_t;

endpackage

// File: design/ssf_ifs.sv
// ============================================================================
// ssf_ifs
// Valid/ready channels of the steering safety filter: item, result, config.
// ============================================================================
interface ssf_item_if
    import ssf_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic signed [OMEGA_W-1:0] omega_sample;
    logic                      go_in;

    modport source (output valid, op, omega_sample, go_in, input ready);
    modport sink   (input valid, op, omega_sample, go_in, output ready);
endinterface

interface ssf_result_if
    import ssf_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic [SPEED_W-1:0]        linear_cmd;
    logic signed [OMEGA_W-1:0] angular_cmd;
    logic                      stale;

    modport source (output valid, linear_cmd, angular_cmd, stale, input ready);
    modport sink   (input valid, linear_cmd, angular_cmd, stale, output ready);
endinterface

interface ssf_cfg_if
    import ssf_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/ssf_alu.sv
// ============================================================================
// ssf_alu
// Shared arithmetic: signed multiplier and one restoring divide step.
// ============================================================================
module ssf_alu
    import ssf_pkg::*;
(
    input  logic signed [MUL_X_W-1:0] mul_x,
    input  logic signed [MUL_Y_W-1:0] mul_y,
    output logic signed [PROD_W-1:0]  prod,
    input  logic [DEN_W-1:0]          rem,
    input  logic                      num_bit,
    input  logic [DEN_W-1:0]          den,
    output logic [DEN_W-1:0]          rem_next,
    output logic                      q_bit
);

    logic [DEN_W:0] shifted;
    logic [DEN_W:0] trial;

    assign prod    = mul_x * mul_y;
    assign shifted = {rem, num_bit};
    assign trial   = shifted - {1'b0, den};
    assign q_bit   = (shifted >= {1'b0, den});

    always_comb
    begin
        if (q_bit)
        begin
            rem_next = trial[DEN_W-1:0];
        end
        else
        begin
            rem_next = shifted[DEN_W-1:0];
        end
    end

endmodule

// File: design/steering_safety_filter_unit.sv
// ============================================================================
// steering_safety_filter_unit
// Watchdog, exponential smoothing, clamp and turn slowdown of a velocity cmd.
//
//  channel  dir  handshake      payload
//  item     in   valid/ready    op, omega_sample, go_in
//  result   out  valid/ready    linear_cmd, angular_cmd, stale
//  cfg      in   valid/ready    index, data
//
//  Sample and go items finish in S_IDLE. A stale tick goes on to S_OUT; a
//  tick without slowdown (go low or turn_slowdown zero) runs S_MUL1, S_MUL2,
//  S_SUM, S_OUT; a full tick adds S_MUL3, S_DIFF, S_MUL4 and a 15-step
//  restoring divider; one shared 24x17 multiplier serves S_MUL1-4.
//  rst_n resets all state and loads the register defaults asynchronously.
//  The result register holds until taken; a tick waits in its final state
//  only while the previous result is still pending. cfg is always ready.
// ============================================================================
module steering_safety_filter_unit
    import ssf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ssf_item_if.sink     item,
    ssf_result_if.source result,
    ssf_cfg_if.sink      cfg
);

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]  gain_reg;
    logic [SPEED_W-1:0] limit_reg;
    logic [SPEED_W-1:0] cruise_reg;
    logic [SLOW_W-1:0]  slow_reg;
    logic [AGE_W-1:0]   stale_lim_reg;
    logic               need_go_reg;

    logic signed [OMEGA_W-1:0] smooth_reg;
    logic signed [OMEGA_W-1:0] latest_reg;
    logic                      seen_reg;
    logic [AGE_W-1:0]          age_reg;
    logic                      go_seen_reg;
    logic                      go_val_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [SPEED_W-1:0]       quo_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [SPEED_W-1:0]       lin_reg;
    logic                     stale_reg;

    logic                      out_valid_reg;
    logic [SPEED_W-1:0]        out_lin_reg;
    logic signed [OMEGA_W-1:0] out_ang_reg;
    logic                      out_stale_reg;

    logic [GAIN_W-1:0]         a_eff;
    logic [SLOW_W-1:0]         a_cmp;
    logic [SPEED_W-1:0]        lim_eff;
    logic [SLOW_W-1:0]         slow_eff;
    logic [DEN_W-1:0]          den;
    logic signed [MUL_X_W-1:0] mul_x;
    logic signed [MUL_Y_W-1:0] mul_y;
    logic signed [PROD_W-1:0]  prod;
    logic [DEN_W-1:0]          rem_next;
    logic                      q_bit;
    logic                      item_acc;
    logic                      stale_now;
    logic                      go_now;
    logic                      out_load;
    logic signed [PROD_W-1:0]  sum_t;
    logic signed [OMEGA_W:0]   w_full;
    logic signed [OMEGA_W:0]   lim17;
    logic signed [OMEGA_W:0]   lim_neg17;
    logic signed [OMEGA_W-1:0] w_clamp;
    logic [OMEGA_W-1:0]        mag16;
    logic [SPEED_W-1:0]        mag;
    logic [DEN_W-1:0]          diff;
    logic [NUM_W-1:0]          num_rnd;
    logic signed [OMEGA_W:0]   ang17;

    assign a_eff    = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;
    assign a_cmp    = SLOW_MAX - {1'b0, a_eff};
    assign lim_eff  = (limit_reg == '0) ? SPEED_W'(1) : limit_reg;
    assign slow_eff = (slow_reg > SLOW_MAX) ? SLOW_MAX : slow_reg;
    assign den      = {lim_eff, 8'b0};

    assign item.ready = (state_reg == S_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign stale_now  = !seen_reg || (age_reg > stale_lim_reg);
    assign go_now     = need_go_reg ? (go_seen_reg && go_val_reg) : go_val_reg;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    assign cfg.ready = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.linear_cmd  = out_lin_reg;
    assign result.angular_cmd = out_ang_reg;
    assign result.stale       = out_stale_reg;

    assign sum_t     = acc_reg + prod_reg + PROD_W'(128);
    assign w_full    = sum_t[OMEGA_W+8:8];
    assign lim17     = $signed({2'b0, lim_eff});
    assign lim_neg17 = -lim17;
    assign mag16     = smooth_reg[OMEGA_W-1] ? (-smooth_reg) : smooth_reg;
    assign mag       = mag16[SPEED_W-1:0];
    assign diff      = den - prod_reg[DEN_W-1:0];
    assign num_rnd   = prod_reg[NUM_W-1:0] + NUM_W'({lim_eff, 7'b0});
    assign ang17     = {result.angular_cmd[OMEGA_W-1], result.angular_cmd};

    always_comb
    begin
        if (w_full > lim17)
        begin
            w_clamp = lim17[OMEGA_W-1:0];
        end
        else if (w_full < lim_neg17)
        begin
            w_clamp = lim_neg17[OMEGA_W-1:0];
        end
        else
        begin
            w_clamp = w_full[OMEGA_W-1:0];
        end
    end

    always_comb
    begin
        case (state_reg)
            S_MUL1:
            begin
                mul_x = {{(MUL_X_W-OMEGA_W){smooth_reg[OMEGA_W-1]}}, smooth_reg};
                mul_y = $signed({{(MUL_Y_W-GAIN_W){1'b0}}, a_eff});
            end
            S_MUL2:
            begin
                mul_x = {{(MUL_X_W-OMEGA_W){latest_reg[OMEGA_W-1]}}, latest_reg};
                mul_y = $signed({{(MUL_Y_W-SLOW_W){1'b0}}, a_cmp});
            end
            S_MUL3:
            begin
                mul_x = $signed({{(MUL_X_W-SPEED_W){1'b0}}, mag});
                mul_y = $signed({{(MUL_Y_W-SLOW_W){1'b0}}, slow_eff});
            end
            S_MUL4:
            begin
                mul_x = acc_reg[MUL_X_W-1:0];
                mul_y = $signed({{(MUL_Y_W-SPEED_W){1'b0}}, cruise_reg});
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    ssf_alu u_alu (
        .mul_x    (mul_x),
        .mul_y    (mul_y),
        .prod     (prod),
        .rem      (rem_reg),
        .num_bit  (quo_reg[SPEED_W-1]),
        .den      (den),
        .rem_next (rem_next),
        .q_bit    (q_bit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_acc && (item.op == OP_TICK))
                begin
                    state_next = stale_now ? S_OUT : S_MUL1;
                end
            end
            S_MUL1:    state_next = S_MUL2;
            S_MUL2:    state_next = S_SUM;
            S_SUM:
            begin
                state_next = (!go_now || (slow_eff == '0)) ? S_OUT : S_MUL3;
            end
            S_MUL3:    state_next = S_DIFF;
            S_DIFF:    state_next = S_MUL4;
            S_MUL4:    state_next = S_DIVINIT;
            S_DIVINIT: state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RST;
            limit_reg     <= LIMIT_RST;
            cruise_reg    <= CRUISE_RST;
            slow_reg      <= SLOW_RST;
            stale_lim_reg <= STALE_LIM_RST;
            need_go_reg   <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_GAIN:      gain_reg      <= cfg.data[GAIN_W-1:0];
                CFG_LIMIT:     limit_reg     <= cfg.data[SPEED_W-1:0];
                CFG_CRUISE:    cruise_reg    <= cfg.data[SPEED_W-1:0];
                CFG_SLOW:      slow_reg      <= cfg.data[SLOW_W-1:0];
                CFG_STALE_LIM: stale_lim_reg <= cfg.data[AGE_W-1:0];
                CFG_NEED_GO:   need_go_reg   <= cfg.data[0];
                default:       ;
            endcase
        end
    end

    // filter state and sequencer datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg  <= '0;
            latest_reg  <= '0;
            seen_reg    <= 1'b0;
            age_reg     <= '0;
            go_seen_reg <= 1'b0;
            go_val_reg  <= 1'b1;
            prod_reg    <= '0;
            acc_reg     <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            cnt_reg     <= '0;
            lin_reg     <= '0;
            stale_reg   <= 1'b0;
        end
        else
        begin
            if (item_acc)
            begin
                case (item.op)
                    OP_SAMPLE:
                    begin
                        latest_reg <= item.omega_sample;
                        seen_reg   <= 1'b1;
                        age_reg    <= '0;
                    end
                    OP_GO:
                    begin
                        go_val_reg  <= item.go_in;
                        go_seen_reg <= 1'b1;
                    end
                    OP_TICK:
                    begin
                        if (age_reg != AGE_MAX)
                        begin
                            age_reg <= age_reg + AGE_W'(1);
                        end
                        stale_reg <= stale_now;
                        if (stale_now)
                        begin
                            smooth_reg <= '0;
                            lin_reg    <= '0;
                        end
                    end
                    default: ;
                endcase
            end

            case (state_reg)
                S_MUL1:
                begin
                    prod_reg <= prod;
                end
                S_MUL2:
                begin
                    prod_reg <= prod;
                    acc_reg  <= prod_reg;
                end
                S_SUM:
                begin
                    smooth_reg <= w_clamp;
                    if (!go_now)
                    begin
                        lin_reg <= '0;
                    end
                    else
                    begin
                        lin_reg <= cruise_reg;
                    end
                end
                S_MUL3:
                begin
                    prod_reg <= prod;
                end
                S_DIFF:
                begin
                    acc_reg <= PROD_W'(diff);
                end
                S_MUL4:
                begin
                    prod_reg <= prod;
                end
                S_DIVINIT:
                begin
                    rem_reg <= num_rnd[NUM_W-1:SPEED_W];
                    quo_reg <= num_rnd[SPEED_W-1:0];
                    cnt_reg <= '0;
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[SPEED_W-2:0], q_bit};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    lin_reg <= {quo_reg[SPEED_W-2:0], q_bit};
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_lin_reg   <= '0;
            out_ang_reg   <= '0;
            out_stale_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_lin_reg   <= lin_reg;
                out_ang_reg   <= smooth_reg;
                out_stale_reg <= stale_reg;
            end
            else if (result.valid && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_div_rem_below_den: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den))
        else $error("divider remainder not below divisor");

    a_stale_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.stale) |->
            ((result.linear_cmd == '0) && (result.angular_cmd == '0)))
        else $error("stale transaction carries nonzero command");

    a_angular_clamped: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && !result.stale) |-> ((ang17 <= lim17) && (ang17 >= lim_neg17)))
        else $error("angular command outside clamp");

    a_sample_clears_age: assert property (
        @(posedge clk) disable iff (!rst_n)
        (item_acc && (item.op == OP_SAMPLE)) |=> ((age_reg == '0) && seen_reg))
        else $error("sample did not reset watchdog");

    a_lin_within_cruise: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.linear_cmd <= cruise_reg))
        else $error("linear command above cruise speed");

endmodule
